FILE: rtl/core/cscd_pkg.sv
// Shared types, widths, register indexes and helpers of the sleepy CUSUM change detector.
// No dependencies; every module of the core imports this package.
package cscd_pkg;

    localparam int SAMPLE_BITS_DEF = 12;

    localparam int MEAN_W     = 12;
    localparam int VAR_W      = 26;
    localparam int STAT_W     = 16;
    localparam int THR_W      = 15;
    localparam int MU_W       = 15;
    localparam int QUOT_W     = 15;
    localparam int TICKS_W    = 12;
    localparam int Z_W        = 18;
    localparam int STEP_W     = 4;
    localparam int SQ_EXT_W   = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic signed [Z_W-1:0]    HALF_LIMIT = 18'sd16384;
    localparam logic signed [Z_W-1:0]    SUM_MAX    = 18'sd32767;
    localparam logic signed [Z_W-1:0]    SUM_MIN    = -18'sd32768;
    localparam logic signed [STAT_W-1:0] STAT_MAX   = 16'sd32767;
    localparam logic signed [STAT_W-1:0] STAT_NEG   = -16'sd32767;
    localparam logic [TICKS_W-1:0]       TICKS_MAX  = 12'd4095;
    localparam logic [STEP_W-1:0]        QUOT_STEPS = 4'd15;
    localparam logic [STEP_W-1:0]        TICK_STEPS = 4'd12;

    localparam logic [CFG_IDX_W-1:0] REG_MEAN_PRE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEAN_POST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TVAR_PRE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TVAR_POST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOG_OFFSET = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MU         = 3'd6;

    // Status of a serial arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    // Halving with truncation toward zero.
    function automatic logic signed [Z_W-1:0] half_toward_zero(input logic signed [Z_W-1:0] x);
        logic signed [Z_W-1:0] adj;
        adj = x + $signed({{(Z_W-1){1'b0}}, x[Z_W-1]});
        return adj >>> 1;
    endfunction

endpackage

FILE: rtl/core/cscd_sqr.sv
// Bit-serial squarer: one multiplier bit per cycle, most significant bit first.
// Depends on cscd_pkg for the unit status struct.
module cscd_sqr #(
    parameter int D_W = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [D_W-1:0]        operand,
    output logic [2*D_W-1:0]      product,
    output cscd_pkg::unit_stat_t  stat
);
    import cscd_pkg::*;

    localparam int CNT_W = $clog2(D_W + 1);

    logic [2*D_W-1:0] acc_reg;
    logic [D_W-1:0]   shift_reg;
    logic [D_W-1:0]   mcand_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !start && busy_reg && (cnt_reg == CNT_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(D_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg   <= '0;
            shift_reg <= operand;
            mcand_reg <= operand;
        end else if (busy_reg) begin
            acc_reg   <= (acc_reg << 1)
                       + (shift_reg[D_W-1] ? (2*D_W)'(mcand_reg) : '0);
            shift_reg <= shift_reg << 1;
        end
    end

    assign product   = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

FILE: rtl/core/cscd_div.sv
// Restoring serial divider shared by the three quotients, one quotient bit per cycle.
// Depends on cscd_pkg for widths and the unit status struct.
module cscd_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [cscd_pkg::VAR_W-1:0]        rem_init,
    input  logic [cscd_pkg::QUOT_W-1:0]       low_bits,
    input  logic [cscd_pkg::VAR_W-1:0]        divisor,
    input  logic [cscd_pkg::STEP_W-1:0]       steps,
    output logic [cscd_pkg::QUOT_W-1:0]       quotient,
    output logic [cscd_pkg::VAR_W-1:0]        remainder,
    output cscd_pkg::unit_stat_t              stat
);
    import cscd_pkg::*;

    logic [VAR_W-1:0]  rem_reg;
    logic [QUOT_W-1:0] low_reg;
    logic [QUOT_W-1:0] quo_reg;
    logic [VAR_W-1:0]  dvs_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [VAR_W:0] trial;
    logic [VAR_W:0] diff;
    logic           fits;

    // The partial remainder stays below the divisor, so the trial value fits VAR_W+1 bits.
    assign trial = {rem_reg, low_reg[QUOT_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !start && busy_reg && (cnt_reg == STEP_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= rem_init;
            low_reg <= low_bits;
            quo_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[VAR_W-1:0] : trial[VAR_W-1:0];
            low_reg <= low_reg << 1;
            quo_reg <= {quo_reg[QUOT_W-2:0], fits};
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

FILE: rtl/core/sleepy_cusum_change_detector_core.sv
// Sleepy CUSUM change detector core: sequencer, configuration registers and result register.
// Depends on cscd_pkg, cscd_sqr and cscd_div.
// A sample passes in order through the post squaring, the post division, the pre squaring,
// the pre division, the increment, statistic and sleep states and, when the block sleeps and
// divides, a sleep division. The squarer and the shared divider work one bit per cycle, one
// sample in flight; a new one is taken in idle. Reset: synchronous, active low; clears state.
module sleepy_cusum_change_detector_core #(
    parameter int SAMPLE_BITS = cscd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Configuration write channel.
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [cscd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [cscd_pkg::CFG_DATA_W-1:0]       cfg_data,
    // Sample input channel.
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [SAMPLE_BITS-1:0]                s_sample,
    // Result channel.
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [cscd_pkg::STAT_W-1:0]    m_statistic,
    output logic                                  m_change_detected,
    output logic                                  m_sleeping,
    output logic [cscd_pkg::TICKS_W-1:0]          m_sleep_ticks,
    output logic signed [cscd_pkg::STAT_W-1:0]    m_statistic_after_sleep
);
    import cscd_pkg::*;

    // The squared distance is taken over the wider of the sample and the mean.
    localparam int D_W  = (SAMPLE_BITS > MEAN_W) ? SAMPLE_BITS : MEAN_W;
    localparam int SQ_W = 2 * D_W;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_SQ_POST   = 4'd1;
    localparam logic [3:0] ST_DIV_POST  = 4'd2;
    localparam logic [3:0] ST_SQ_PRE    = 4'd3;
    localparam logic [3:0] ST_DIV_PRE   = 4'd4;
    localparam logic [3:0] ST_ZSUM      = 4'd5;
    localparam logic [3:0] ST_STAT      = 4'd6;
    localparam logic [3:0] ST_SLEEP     = 4'd7;
    localparam logic [3:0] ST_SLEEP_DIV = 4'd8;
    localparam logic [3:0] ST_FINISH    = 4'd9;

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always accepted; an index past
    // the last register is dropped.
    // ------------------------------------------------------------------
    logic [MEAN_W-1:0]        mean_pre_reg;
    logic [MEAN_W-1:0]        mean_post_reg;
    logic [VAR_W-1:0]         tvar_pre_reg;
    logic [VAR_W-1:0]         tvar_post_reg;
    logic signed [STAT_W-1:0] log_offset_reg;
    logic [THR_W-1:0]         threshold_reg;
    logic [MU_W-1:0]          mu_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mean_pre_reg   <= MEAN_W'(0);
            mean_post_reg  <= MEAN_W'(1);
            tvar_pre_reg   <= VAR_W'(2);
            tvar_post_reg  <= VAR_W'(2);
            log_offset_reg <= '0;
            threshold_reg  <= THR_W'(500);
            mu_reg         <= MU_W'(50);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_MEAN_PRE:   mean_pre_reg   <= cfg_data[MEAN_W-1:0];
                REG_MEAN_POST:  mean_post_reg  <= cfg_data[MEAN_W-1:0];
                REG_TVAR_PRE:   tvar_pre_reg   <= cfg_data[VAR_W-1:0];
                REG_TVAR_POST:  tvar_post_reg  <= cfg_data[VAR_W-1:0];
                REG_LOG_OFFSET: log_offset_reg <= $signed(cfg_data[STAT_W-1:0]);
                REG_THRESHOLD:  threshold_reg  <= cfg_data[THR_W-1:0];
                REG_MU:         mu_reg         <= cfg_data[MU_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and datapath registers.
    // ------------------------------------------------------------------
    logic [3:0]               state_reg;
    logic [SAMPLE_BITS-1:0]   sample_reg;
    logic [QUOT_W-1:0]        qpost_reg;
    logic [QUOT_W-1:0]        qpre_reg;
    logic                     sat_post_reg;
    logic                     sat_pre_reg;
    logic signed [Z_W-1:0]    z_reg;
    logic signed [STAT_W-1:0] st_reg;
    logic                     chg_reg;
    logic                     slp_reg;
    logic [TICKS_W-1:0]       ticks_reg;
    logic signed [STAT_W-1:0] after_reg;
    logic signed [STAT_W-1:0] cusum_stat_reg;

    logic                     m_valid_reg;
    logic signed [STAT_W-1:0] m_stat_reg;
    logic                     m_chg_reg;
    logic                     m_slp_reg;
    logic [TICKS_W-1:0]       m_ticks_reg;
    logic signed [STAT_W-1:0] m_after_reg;

    logic s_transfer;
    logic out_free;

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_transfer = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;

    // Distance of a sample from a mean, over D_W bits.
    function automatic logic [D_W-1:0] abs_diff(input logic [D_W-1:0] a, input logic [D_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // Serial squarer.
    logic             sq_start;
    logic [D_W-1:0]   sq_operand;
    logic [SQ_W-1:0]  sq_product;
    unit_stat_t       sq_stat;
    unit_stat_t       div_stat;

    // Squaring of the post distance starts on the input transfer, the pre
    // distance when the post quotient is done.
    assign sq_start   = s_transfer || ((state_reg == ST_DIV_POST) && div_stat.done);
    assign sq_operand = s_transfer
                      ? abs_diff(D_W'(s_sample), D_W'(mean_post_reg))
                      : abs_diff(D_W'(sample_reg), D_W'(mean_pre_reg));

    cscd_sqr #(
        .D_W(D_W)
    ) u_sqr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .operand (sq_operand),
        .product (sq_product),
        .stat    (sq_stat)
    );

    // The square is split at bit 15: the upper part seeds the remainder and
    // the lower 15 bits are shifted in. When the upper part already reaches
    // the divisor the quotient would pass 32767, which also covers a zero divisor.
    logic [SQ_EXT_W-1:0] sq_ext;
    logic [VAR_W-1:0]    sq_hi;
    logic [QUOT_W-1:0]   sq_lo;

    assign sq_ext = SQ_EXT_W'(sq_product);
    assign sq_hi  = sq_ext[QUOT_W+VAR_W-1:QUOT_W];
    assign sq_lo  = sq_ext[QUOT_W-1:0];

    // Sleep quantities: the negated statistic is split at bit 12 so that only
    // twelve quotient bits are formed; a seed that reaches mu means the tick
    // count clamps.
    logic [STAT_W-1:0]     neg_st;
    logic                  st_change;
    logic                  st_sleep;
    logic                  tick_clamp;
    logic [27:0]           clamp_sum;

    assign neg_st     = STAT_W'(0) - st_reg;
    assign st_change  = ($signed(st_reg) >= $signed({1'b0, threshold_reg}));
    assign st_sleep   = st_reg[STAT_W-1] && !st_change;
    assign tick_clamp = (MU_W'(neg_st[STAT_W-1:TICKS_W]) >= mu_reg);
    assign clamp_sum  = {{12{st_reg[STAT_W-1]}}, st_reg}
                      + {1'b0, mu_reg, 12'b0}
                      - {13'b0, mu_reg};

    // Shared serial divider.
    logic              div_start;
    logic [VAR_W-1:0]  div_rem_init;
    logic [QUOT_W-1:0] div_low;
    logic [VAR_W-1:0]  div_divisor;
    logic [STEP_W-1:0] div_steps;
    logic [QUOT_W-1:0] div_quo;
    logic [VAR_W-1:0]  div_rem;

    always_comb begin
        div_start    = 1'b0;
        div_rem_init = sq_hi;
        div_low      = sq_lo;
        div_divisor  = tvar_post_reg;
        div_steps    = QUOT_STEPS;
        unique case (state_reg)
            ST_SQ_POST: begin
                div_start = sq_stat.done;
            end
            ST_SQ_PRE: begin
                div_start   = sq_stat.done;
                div_divisor = tvar_pre_reg;
            end
            ST_SLEEP: begin
                div_start    = st_sleep && (mu_reg != '0) && !tick_clamp;
                div_rem_init = VAR_W'(neg_st[STAT_W-1:TICKS_W]);
                div_low      = {neg_st[TICKS_W-1:0], {(QUOT_W-TICKS_W){1'b0}}};
                div_divisor  = VAR_W'(mu_reg);
                div_steps    = TICK_STEPS;
            end
            default: ;
        endcase
    end

    cscd_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .rem_init  (div_rem_init),
        .low_bits  (div_low),
        .divisor   (div_divisor),
        .steps     (div_steps),
        .quotient  (div_quo),
        .remainder (div_rem),
        .stat      (div_stat)
    );

    // Statistic update from the current state and the increment.
    logic signed [Z_W-1:0]    z_next;
    logic signed [Z_W-1:0]    st_ext;
    logic signed [Z_W-1:0]    half_sum;
    logic signed [Z_W-1:0]    full_sum;
    logic signed [STAT_W-1:0] st_next;

    assign z_next = Z_W'(log_offset_reg)
                  - $signed({{(Z_W-QUOT_W){1'b0}}, qpost_reg})
                  + $signed({{(Z_W-QUOT_W){1'b0}}, qpre_reg});
    assign st_ext   = Z_W'(cusum_stat_reg);
    assign half_sum = half_toward_zero(st_ext) + half_toward_zero(z_reg);
    assign full_sum = st_ext + z_reg;

    always_comb begin
        if (half_sum > HALF_LIMIT) begin
            st_next = STAT_MAX;
        end else if (full_sum > SUM_MAX) begin
            st_next = STAT_MAX;
        end else if (full_sum < SUM_MIN) begin
            st_next = SUM_MIN[STAT_W-1:0];
        end else begin
            st_next = full_sum[STAT_W-1:0];
        end
        // A quotient at its cap forces the statistic; the pre term wins. A
        // quotient of exactly 32767 counts as capped as well.
        if (sat_post_reg || (&qpost_reg)) begin
            st_next = STAT_NEG;
        end
        if (sat_pre_reg || (&qpre_reg)) begin
            st_next = STAT_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cusum_stat_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if ((state_reg == ST_FINISH) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_transfer) begin
                        state_reg <= ST_SQ_POST;
                    end
                end
                ST_SQ_POST: begin
                    if (sq_stat.done) begin
                        state_reg <= ST_DIV_POST;
                    end
                end
                ST_DIV_POST: begin
                    if (div_stat.done) begin
                        state_reg <= ST_SQ_PRE;
                    end
                end
                ST_SQ_PRE: begin
                    if (sq_stat.done) begin
                        state_reg <= ST_DIV_PRE;
                    end
                end
                ST_DIV_PRE: begin
                    if (div_stat.done) begin
                        state_reg <= ST_ZSUM;
                    end
                end
                ST_ZSUM: begin
                    state_reg <= ST_STAT;
                end
                ST_STAT: begin
                    state_reg <= ST_SLEEP;
                end
                ST_SLEEP: begin
                    state_reg <= div_start ? ST_SLEEP_DIV : ST_FINISH;
                end
                ST_SLEEP_DIV: begin
                    if (div_stat.done) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        cusum_stat_reg <= after_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        if (s_transfer) begin
            sample_reg <= s_sample;
        end
        if ((state_reg == ST_SQ_POST) && sq_stat.done) begin
            sat_post_reg <= (sq_hi >= tvar_post_reg);
        end
        if ((state_reg == ST_SQ_PRE) && sq_stat.done) begin
            sat_pre_reg <= (sq_hi >= tvar_pre_reg);
        end
        if ((state_reg == ST_DIV_POST) && div_stat.done) begin
            qpost_reg <= div_quo;
        end
        if ((state_reg == ST_DIV_PRE) && div_stat.done) begin
            qpre_reg <= div_quo;
        end
        if (state_reg == ST_ZSUM) begin
            z_reg <= z_next;
        end
        if (state_reg == ST_STAT) begin
            st_reg <= st_next;
        end
        if (state_reg == ST_SLEEP) begin
            chg_reg <= st_change;
            slp_reg <= st_sleep;
            if (st_sleep && (mu_reg == '0)) begin
                ticks_reg <= TICKS_MAX;
                after_reg <= st_reg;
            end else if (st_sleep && tick_clamp) begin
                ticks_reg <= TICKS_MAX;
                after_reg <= $signed(clamp_sum[STAT_W-1:0]);
            end else begin
                ticks_reg <= '0;
                after_reg <= st_reg;
            end
        end
        // The final remainder is -statistic - ticks*mu, so the advanced
        // statistic is its negation.
        if ((state_reg == ST_SLEEP_DIV) && div_stat.done) begin
            ticks_reg <= div_quo[TICKS_W-1:0];
            after_reg <= $signed(STAT_W'(0) - div_rem[STAT_W-1:0]);
        end
        if ((state_reg == ST_FINISH) && out_free) begin
            m_stat_reg  <= st_reg;
            m_chg_reg   <= chg_reg;
            m_slp_reg   <= slp_reg;
            m_ticks_reg <= ticks_reg;
            m_after_reg <= after_reg;
        end
    end

    assign m_valid                 = m_valid_reg;
    assign m_statistic             = m_stat_reg;
    assign m_change_detected       = m_chg_reg;
    assign m_sleeping              = m_slp_reg;
    assign m_sleep_ticks           = m_ticks_reg;
    assign m_statistic_after_sleep = m_after_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // Only one sample is in flight: a transfer closes the input at once.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a sample is in flight");

    // The squarer and the shared divider never run together.
    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(sq_stat.busy && div_stat.busy))
        else $error("squarer and divider busy at the same time");

    // Without sleep the statistic is not advanced and no ticks are reported.
    a_awake_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_sleeping |->
            (m_statistic_after_sleep == m_statistic) && (m_sleep_ticks == '0))
        else $error("awake result carries a sleep advance");

    // A sleep advance moves the statistic up but never past zero.
    a_sleep_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_sleeping |->
            !m_change_detected && (m_statistic_after_sleep <= 0)
            && (m_statistic_after_sleep >= m_statistic))
        else $error("sleep advance out of range");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for sleepy_cusum_change_detector_core: directed and random samples
// under several register settings, checked against an in-bench CUSUM predictor.
// Depends on cscd_pkg and the core RTL only.
module tb;

    localparam int SAMPLE_W = cscd_pkg::SAMPLE_BITS_DEF;

    // Saturation limits of the detector arithmetic, the largest drawn variance and the largest sample.
    localparam int QUOT_CAP = 32767;
    localparam int HALF_CAP = 16384;
    localparam int STAT_HI  = 32767;
    localparam int STAT_LO  = -32768;
    localparam int TICK_CAP = 4095;
    localparam int unsigned TVAR_MAX = 33554432;
    localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;

    // How the two channels pause during a phase.
    typedef enum int {
        NO_IDLE,
        SENDER_IDLE,
        RECEIVER_IDLE,
        BOTH_IDLE
    } idle_mode_t;

    // One copy of the register file.
    typedef struct {
        logic [cscd_pkg::MEAN_W-1:0]        mean_pre;
        logic [cscd_pkg::MEAN_W-1:0]        mean_post;
        logic [cscd_pkg::VAR_W-1:0]         tvar_pre;
        logic [cscd_pkg::VAR_W-1:0]         tvar_post;
        logic signed [cscd_pkg::STAT_W-1:0] log_offset;
        logic [cscd_pkg::THR_W-1:0]         threshold;
        logic [cscd_pkg::MU_W-1:0]          mu;
    } detector_cfg_t;

    // One result transfer as the core should produce it.
    typedef struct {
        logic signed [cscd_pkg::STAT_W-1:0] statistic;
        logic                               change_detected;
        logic                               sleeping;
        logic [cscd_pkg::TICKS_W-1:0]       sleep_ticks;
        logic signed [cscd_pkg::STAT_W-1:0] statistic_after_sleep;
    } detection_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [cscd_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [cscd_pkg::CFG_DATA_W-1:0]   cfg_data  = '0;

    logic                              s_valid  = 1'b0;
    logic                              s_ready;
    logic [SAMPLE_W-1:0]               s_sample = '0;

    logic                              m_valid;
    logic                              m_ready  = 1'b0;
    logic signed [cscd_pkg::STAT_W-1:0] m_statistic;
    logic                              m_change_detected;
    logic                              m_sleeping;
    logic [cscd_pkg::TICKS_W-1:0]      m_sleep_ticks;
    logic signed [cscd_pkg::STAT_W-1:0] m_statistic_after_sleep;

    // Samples waiting to be offered, and detections waiting to come out.
    logic [SAMPLE_W-1:0] sample_queue[$];
    detection_t          detection_queue[$];

    // Shadow of the register file and of the CUSUM statistic.
    detector_cfg_t                      live_cfg;
    logic signed [cscd_pkg::STAT_W-1:0] cusum_state;

    idle_mode_t idle_mode = NO_IDLE;
    int         failures  = 0;

    always #1 aclk = ~aclk;

    sleepy_cusum_change_detector_core #(
        .SAMPLE_BITS(SAMPLE_W)
    ) DUT (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cfg_valid              (cfg_valid),
        .cfg_ready              (cfg_ready),
        .cfg_index              (cfg_index),
        .cfg_data               (cfg_data),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_sample               (s_sample),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_statistic            (m_statistic),
        .m_change_detected      (m_change_detected),
        .m_sleeping             (m_sleeping),
        .m_sleep_ticks          (m_sleep_ticks),
        .m_statistic_after_sleep(m_statistic_after_sleep)
    );

    // Squared distance of a sample from a mean over a doubled variance, capped at the
    // quotient limit. A zero divisor counts as a capped quotient.
    function automatic int scaled_distance(input int unsigned sample, input int unsigned mean,
                                           input int unsigned divisor);
        longint unsigned gap;
        longint unsigned quot;
        gap = (sample >= mean) ? longint'(sample - mean) : longint'(mean - sample);
        if (divisor == 0) begin
            return QUOT_CAP;
        end
        quot = (gap * gap) / divisor;
        return (quot > QUOT_CAP) ? QUOT_CAP : int'(quot);
    endfunction

    // Advances the shadow statistic by one sample and returns the detection it produces.
    function automatic detection_t predict_detection(input logic [SAMPLE_W-1:0] sample);
        detection_t det;
        int q_pre;
        int q_post;
        int incr;
        int stat;
        int after;
        int ticks;
        int offset_v;
        int thr_v;
        int mu_v;
        offset_v = live_cfg.log_offset;
        thr_v    = live_cfg.threshold;
        mu_v     = live_cfg.mu;
        q_post   = scaled_distance(sample, live_cfg.mean_post, live_cfg.tvar_post);
        q_pre    = scaled_distance(sample, live_cfg.mean_pre, live_cfg.tvar_pre);
        incr     = offset_v - q_post + q_pre;
        stat     = cusum_state;
        // The halves truncate toward zero, just as integer division does here.
        if (stat / 2 + incr / 2 > HALF_CAP) begin
            stat = STAT_HI;
        end else begin
            stat = stat + incr;
            if (stat > STAT_HI) stat = STAT_HI;
            if (stat < STAT_LO) stat = STAT_LO;
        end
        // A capped quotient forces the statistic; the pre-change side has the last word.
        if (q_post == QUOT_CAP) stat = -STAT_HI;
        if (q_pre == QUOT_CAP) stat = STAT_HI;
        after = stat;
        ticks = 0;
        det.change_detected = 1'b0;
        det.sleeping        = 1'b0;
        if (stat >= thr_v) begin
            det.change_detected = 1'b1;
        end else if (stat < 0) begin
            det.sleeping = 1'b1;
            if (mu_v == 0) begin
                ticks = TICK_CAP;
            end else begin
                ticks = (-stat) / mu_v;
                if (ticks > TICK_CAP) ticks = TICK_CAP;
                after = stat + ticks * mu_v;
            end
        end
        cusum_state                = after[cscd_pkg::STAT_W-1:0];
        det.statistic              = stat[cscd_pkg::STAT_W-1:0];
        det.sleep_ticks            = ticks[cscd_pkg::TICKS_W-1:0];
        det.statistic_after_sleep  = after[cscd_pkg::STAT_W-1:0];
        return det;
    endfunction

    function automatic bit pause_now(input idle_mode_t own_mode);
        if (idle_mode == own_mode) return $urandom_range(0, 99) < 56;
        if (idle_mode == BOTH_IDLE) return $urandom_range(0, 99) < 11;
        return 1'b0;
    endfunction

    // Sample driver. The prediction is made at the edge where the sample transfer happens,
    // so the shadow statistic always follows the order in which the core takes samples.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                detection_queue.push_back(predict_detection(s_sample));
            end
            // Only touch the channel when it is empty or is being emptied at this edge,
            // which keeps valid and the payload stable while a transfer is pending.
            if (!s_valid || s_ready) begin
                if (sample_queue.size() > 0 && !pause_now(SENDER_IDLE)) begin
                    s_valid  <= 1'b1;
                    s_sample <= sample_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string field, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, field, want_v, got_v);
            failures++;
        end
    endtask

    // Result monitor: every result transfer is matched against the oldest prediction.
    always @(posedge aclk) begin : result_monitor
        detection_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (detection_queue.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual statistic %0d",
                             $time, m_statistic);
                    failures++;
                end else begin
                    want = detection_queue.pop_front();
                    check_field("statistic", want.statistic, m_statistic);
                    check_field("change_detected", want.change_detected, m_change_detected);
                    check_field("sleeping", want.sleeping, m_sleeping);
                    check_field("sleep_ticks", want.sleep_ticks, m_sleep_ticks);
                    check_field("statistic_after_sleep", want.statistic_after_sleep,
                                m_statistic_after_sleep);
                end
            end
            m_ready <= !pause_now(RECEIVER_IDLE);
        end
    end

    // One register write over the configuration channel; the shadow copy follows once the
    // transfer has happened.
    task automatic program_register(input logic [cscd_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [cscd_pkg::CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            cscd_pkg::REG_MEAN_PRE:   live_cfg.mean_pre   = data[cscd_pkg::MEAN_W-1:0];
            cscd_pkg::REG_MEAN_POST:  live_cfg.mean_post  = data[cscd_pkg::MEAN_W-1:0];
            cscd_pkg::REG_TVAR_PRE:   live_cfg.tvar_pre   = data[cscd_pkg::VAR_W-1:0];
            cscd_pkg::REG_TVAR_POST:  live_cfg.tvar_post  = data[cscd_pkg::VAR_W-1:0];
            cscd_pkg::REG_LOG_OFFSET: live_cfg.log_offset = data[cscd_pkg::STAT_W-1:0];
            cscd_pkg::REG_THRESHOLD:  live_cfg.threshold  = data[cscd_pkg::THR_W-1:0];
            cscd_pkg::REG_MU:         live_cfg.mu         = data[cscd_pkg::MU_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input detector_cfg_t c);
        program_register(cscd_pkg::REG_MEAN_PRE, 32'(c.mean_pre));
        program_register(cscd_pkg::REG_MEAN_POST, 32'(c.mean_post));
        program_register(cscd_pkg::REG_TVAR_PRE, 32'(c.tvar_pre));
        program_register(cscd_pkg::REG_TVAR_POST, 32'(c.tvar_post));
        program_register(cscd_pkg::REG_LOG_OFFSET, 32'(signed'(c.log_offset)));
        program_register(cscd_pkg::REG_THRESHOLD, 32'(c.threshold));
        program_register(cscd_pkg::REG_MU, 32'(c.mu));
    endtask

    // Every sample yields a result, so the core is idle once both queues are empty and no
    // sample is on the channel. Checked on the falling edge, away from the driving edge.
    task automatic wait_drained();
        do @(negedge aclk);
        while (sample_queue.size() != 0 || s_valid || detection_queue.size() != 0);
    endtask

    // A random register set built around a plausible pre/post pair of Gaussians, with the
    // odd extreme thrown in. The spread returned sizes the sample scatter.
    task automatic draw_config(output detector_cfg_t c, output int spread);
        int pre;
        int post;
        int delta;
        int sig_pre;
        int sig_post;
        int pick;
        pre = $urandom_range(0, SAMPLE_MAX);
        if ($urandom_range(0, 9) == 0) pre = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
        delta = $urandom_range(0, 600);
        post  = $urandom_range(0, 1) ? pre + delta : pre - delta;
        if (post < 0) post = 0;
        if (post > SAMPLE_MAX) post = SAMPLE_MAX;
        sig_pre  = $urandom_range(1, 400);
        sig_post = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 400) : sig_pre;
        c.mean_pre  = pre;
        c.mean_post = post;
        c.tvar_pre  = 2 * sig_pre * sig_pre;
        c.tvar_post = 2 * sig_post * sig_post;
        pick = $urandom_range(0, 15);
        if (pick == 0) c.tvar_pre = $urandom_range(0, 1) ? TVAR_MAX : 2;
        if (pick == 1) c.tvar_post = $urandom_range(0, 1) ? TVAR_MAX : 2;
        if (pick == 2) c.tvar_pre = $urandom_range(2, TVAR_MAX);
        if (pick == 3) c.tvar_post = $urandom_range(2, TVAR_MAX);
        c.log_offset = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 400) - 200;
        c.threshold  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32767)
                                                   : $urandom_range(0, 3000);
        pick = $urandom_range(0, 15);
        if (pick == 0) c.mu = $urandom_range(0, 9);
        else if (pick < 3) c.mu = $urandom_range(10, 32767);
        else c.mu = $urandom_range(10, 300);
        spread = 3 * sig_pre + 1;
        if (spread > 2047) spread = 2047;
    endtask

    // Stimulus: a directed walk through the saturation and sleep corners, then random
    // phases that alternate runs of samples near the pre-change mean with runs near the
    // post-change mean, so that the statistic climbs to detections and falls into sleep.
    initial begin : stimulus
        detector_cfg_t cfg;
        int spread;
        int run_left;
        bit near_post;
        int center;
        int smp;

        live_cfg.mean_pre   = 0;
        live_cfg.mean_post  = 1;
        live_cfg.tvar_pre   = 2;
        live_cfg.tvar_post  = 2;
        live_cfg.log_offset = 0;
        live_cfg.threshold  = 500;
        live_cfg.mu         = 50;
        cusum_state         = '0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset values: the statistic climbs roughly by the sample value, and a full-scale
        // sample caps both quotients, where the pre-change side wins.
        sample_queue.push_back(0);
        sample_queue.push_back(1);
        sample_queue.push_back(2);
        sample_queue.push_back(100);
        sample_queue.push_back(242);
        sample_queue.push_back(243);
        sample_queue.push_back(SAMPLE_MAX);
        sample_queue.push_back(0);
        wait_drained();

        // Capped post quotient forces the statistic negative; zero mu saturates the ticks
        // with no advance; a large negative increment clamps at the bottom of the range.
        cfg = '{mean_pre: SAMPLE_MAX, mean_post: 0, tvar_pre: TVAR_MAX, tvar_post: 2,
                log_offset: 0, threshold: 32767, mu: 0};
        idle_mode = SENDER_IDLE;
        apply_config(cfg);
        sample_queue.push_back(SAMPLE_MAX);
        sample_queue.push_back(0);
        sample_queue.push_back(50);
        sample_queue.push_back(SAMPLE_MAX);
        wait_drained();

        // Zero post divisor and mu of one: the tick count clamps and the advance uses it.
        cfg = '{mean_pre: 2048, mean_post: SAMPLE_MAX, tvar_pre: TVAR_MAX, tvar_post: 0,
                log_offset: -32768, threshold: 0, mu: 1};
        idle_mode = RECEIVER_IDLE;
        apply_config(cfg);
        sample_queue.push_back(0);
        sample_queue.push_back(2048);
        wait_drained();

        // Both divisors zero: both quotients cap and the positive force wins.
        cfg.tvar_pre = 0;
        idle_mode = BOTH_IDLE;
        apply_config(cfg);
        sample_queue.push_back(SAMPLE_MAX);
        sample_queue.push_back(1);
        wait_drained();

        // Largest offset drives the half-sum test past its limit.
        cfg = '{mean_pre: 0, mean_post: 0, tvar_pre: TVAR_MAX, tvar_post: TVAR_MAX,
                log_offset: 32767, threshold: 32767, mu: 10};
        idle_mode = NO_IDLE;
        apply_config(cfg);
        sample_queue.push_back(7);
        sample_queue.push_back(7);
        wait_drained();

        // Most negative offset from the top: a fall to -1, then clamps at the bottom with
        // the largest mu, and finally the longest sleep with the smallest normal mu.
        cfg.log_offset = -32768;
        cfg.mu         = 32767;
        apply_config(cfg);
        sample_queue.push_back(7);
        sample_queue.push_back(7);
        sample_queue.push_back(7);
        wait_drained();
        cfg.mu = 10;
        apply_config(cfg);
        sample_queue.push_back(7);
        wait_drained();

        for (int phase = 0; phase < 14; phase++) begin
            draw_config(cfg, spread);
            idle_mode = idle_mode_t'(phase % 4);
            apply_config(cfg);
            run_left  = $urandom_range(8, 40);
            near_post = 1'b0;
            for (int k = 0; k < 125; k++) begin
                if ($urandom_range(0, 99) < 15) begin
                    smp = $urandom_range(0, SAMPLE_MAX);
                end else begin
                    run_left--;
                    if (run_left <= 0) begin
                        near_post = !near_post;
                        run_left  = $urandom_range(8, 40);
                    end
                    center = near_post ? int'(cfg.mean_post) : int'(cfg.mean_pre);
                    smp = center + int'($urandom_range(0, 2 * spread)) - spread;
                    if (smp < 0) smp = 0;
                    if (smp > SAMPLE_MAX) smp = SAMPLE_MAX;
                end
                sample_queue.push_back(smp);
            end
            wait_drained();
        end

        // Leave room for a stray late result to show up before the verdict.
        repeat (200) @(posedge aclk);
        if (failures == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #3000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
